FILE: src/node_table_best_fit_selector_top_assert.svh
// Assertion macros for the node table selector.
// Every check is sampled on the rising edge of clk and is held off while rst is high.
`ifndef NODE_TABLE_BEST_FIT_SELECTOR_TOP_ASSERT_SVH
`define NODE_TABLE_BEST_FIT_SELECTOR_TOP_ASSERT_SVH

// Checks a property after reset has been released.
`define NBFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication whose consequent is checked in the cycle after the antecedent.
`define NBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nbfs_pkg.sv
// ----------------------------------------------------------------------------
// nbfs_pkg
// Types, codes and helper functions shared by the node table selector.
// ----------------------------------------------------------------------------
`default_nettype none

package nbfs_pkg;

  localparam int ID_W   = 8;
  localparam int PCT_W  = 7;
  localparam int NUM_W  = 14;
  localparam int LAT_W  = 16;
  localparam int DEN_W  = 17;
  localparam int PROD_W = 31;

  localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;
  localparam logic [PCT_W-1:0] THRESH_RESET  = 7'd90;
  localparam logic [LAT_W-1:0] LAT_DEFAULT   = 16'd10;
  localparam logic [NUM_W-1:0] NUM_IDLE_NODE = 14'd10000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_ROT,
    CELL_SHIFT
  } cell_op_t;

  // One table entry; num caches (100-cpu)*(100-mem).
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             degraded;
    logic [PCT_W-1:0] cpu;
    logic [NUM_W-1:0] num;
    logic [LAT_W-1:0] latency;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctl_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/node_table_best_fit_selector_top.sv
// ----------------------------------------------------------------------------
// node_table_best_fit_selector_top
// Packed node table held in a row of cells that rotates past a head cell.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  cmd node_key cpu_pct mem_pct node_lat lat_limit
// out       source     out_valid/ out_stall status result_id node_count
// cfg       sink       cfg_wr_en            cfg_wr_data (overload_threshold)
//
// Add, and any command on an empty table, go from idle straight to the done state.
// Remove and update scan the row, one row rotation step per entry.
// Find best: each entry passes a cross-multiply state, then a scan step.
// Reset clears the count and the threshold to 90; table contents are not cleared.
// A new beat is taken while a result still waits in the output register.
`default_nettype none

module node_table_best_fit_selector_top import nbfs_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       node_key,
  input  wire logic [6:0]       cpu_pct,
  input  wire logic [6:0]       mem_pct,
  input  wire logic [15:0]      node_lat,
  input  wire logic [15:0]      lat_limit,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  status,
  output logic [7:0]            result_id,
  output logic [4:0]            node_count,
  input  wire logic             cfg_wr_en,
  input  wire logic [6:0]       cfg_wr_data
);

  localparam int CW = $clog2(MAX_NODES + 1);

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic [PCT_W-1:0] thresh;

  cmd_t            cmd_r;
  logic [ID_W-1:0] key_r;
  logic [PCT_W-1:0] cpu_r;
  logic [NUM_W-1:0] num_r;
  logic [LAT_W-1:0] lat_r;
  logic [LAT_W-1:0] lim_r;
  logic            deg_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   k;
  logic            found;
  logic            have;
  logic [NUM_W-1:0] best_num;
  logic [DEN_W-1:0] best_den;
  logic [ID_W-1:0] best_id;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic            elig_r;
  logic            res_fail;
  logic [ID_W-1:0] res_id;

  entry_t    cell_q [MAX_NODES];
  entry_t    head, head_mod, new_entry;
  cell_ctl_t ctl;

  logic acc, room, match, better, last, out_free;
  logic [PCT_W-1:0] cpu_c, mem_c;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign room     = (count < CW'(MAX_NODES));
  assign head     = cell_q[0];
  assign match    = !found && (head.id == key_r);
  assign better   = elig_r && (!have || (prod_a > prod_b));
  assign last     = (k == (n_r - 1'b1));
  assign cpu_c    = clamp_pct(cpu_pct);
  assign mem_c    = clamp_pct(mem_pct);

  always_comb begin
    new_entry          = '0;
    new_entry.id       = ID_W'(count) + 1'b1;
    new_entry.num      = NUM_IDLE_NODE;
    new_entry.latency  = LAT_DEFAULT;
    head_mod           = head;
    head_mod.cpu       = cpu_r;
    head_mod.num       = num_r;
    head_mod.latency   = lat_r;
    head_mod.degraded  = deg_r;
  end

  generate
    for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      entry_t nxt;
      if (i == MAX_NODES - 1) begin : g_end
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = cell_q[i+1];
      end
      nbfs_cell #(.CW(CW), .POS(i)) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .count (count),
        .nxt   (nxt),
        .q     (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    ctl.op     = CELL_HOLD;
    ctl.ins    = head;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (cmd_t'(cmd) == CMD_ADD) begin
            if (room) begin
              ctl.op  = CELL_APPEND;
              ctl.ins = new_entry;
            end
            state_next = S_DONE;
          end else if (count == '0) begin
            state_next = S_DONE;
          end else if (cmd_t'(cmd) == CMD_FIND) begin
            state_next = S_MUL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_MUL: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.op = CELL_ROT;
        case (cmd_r)
          CMD_REMOVE: if (match) ctl.op = CELL_SHIFT;
          CMD_UPDATE: if (match) ctl.ins = head_mod;
          default: ;
        endcase
        if (last)                  state_next = S_DONE;
        else if (cmd_r == CMD_FIND) state_next = S_MUL;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      thresh    <= THRESH_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) thresh <= cfg_wr_data;
      if (acc && cmd_t'(cmd) == CMD_ADD && room) count <= count + 1'b1;
      if (state == S_SCAN && cmd_r == CMD_REMOVE && match) count <= count - 1'b1;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          cmd_r    <= cmd_t'(cmd);
          key_r    <= node_key;
          cpu_r    <= cpu_c;
          num_r    <= NUM_W'(PCT_MAX - cpu_c) * NUM_W'(PCT_MAX - mem_c);
          lat_r    <= node_lat;
          lim_r    <= lat_limit;
          deg_r    <= (cpu_c > thresh) || (mem_c > thresh);
          n_r      <= count;
          k        <= '0;
          found    <= 1'b0;
          have     <= 1'b0;
          res_fail <= (cmd_t'(cmd) == CMD_ADD) ? !room : 1'b1;
          res_id   <= (cmd_t'(cmd) == CMD_ADD && room) ? new_entry.id : '0;
        end
      end
      S_MUL: begin
        prod_a <= PROD_W'(head.num) * PROD_W'(best_den);
        prod_b <= PROD_W'(best_num) * PROD_W'(DEN_W'(head.latency) + 1'b1);
        elig_r <= !head.degraded && (head.cpu <= thresh) && (head.latency <= lim_r);
      end
      S_SCAN: begin
        k <= k + 1'b1;
        if (cmd_r != CMD_FIND && match) found <= 1'b1;
        if (cmd_r == CMD_FIND && better) begin
          have     <= 1'b1;
          best_num <= head.num;
          best_den <= DEN_W'(head.latency) + 1'b1;
          best_id  <= head.id;
        end
        if (last) begin
          if (cmd_r == CMD_FIND) begin
            res_fail <= !(have || better);
            res_id   <= better ? head.id : (have ? best_id : '0);
          end else begin
            res_fail <= !(found || match);
            res_id   <= '0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          status     <= res_fail;
          result_id  <= res_id;
          node_count <= 5'(count);
        end
      end
      default: ;
    endcase
  end

`include "node_table_best_fit_selector_top_assert.svh"

  `NBFS_ASSERT(a_count_range, (count <= CW'(MAX_NODES)), "entry count above table depth")
  `NBFS_ASSERT_NEXT(a_busy_after_accept, acc, in_stall, "input not stalled after accepted beat")
  `NBFS_ASSERT_NEXT(a_done_delivers, (state == S_DONE), ((state == S_DONE) || out_valid), "result left done state without output")
  `NBFS_ASSERT_NEXT(a_count_step, 1'b1, ((count == $past(count)) || (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1)), "entry count moved by more than one")

endmodule

`default_nettype wire

FILE: src/nbfs_cell.sv
// ----------------------------------------------------------------------------
// nbfs_cell
// One table slot. Loads from its right neighbor or from the insert bus.
// ----------------------------------------------------------------------------
`default_nettype none

module nbfs_cell import nbfs_pkg::*; #(
  parameter int CW  = 5,
  parameter int POS = 0
) (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic [CW-1:0] count,
  input  wire entry_t    nxt,
  output entry_t         q
);

  localparam logic [CW-1:0] POS_V = CW'(POS);

  logic is_tail;
  logic is_free;

  assign is_tail = (POS_V == (count - 1'b1));
  assign is_free = (POS_V == count);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_APPEND: begin
        if (is_free) q <= ctl.ins;
      end
      // rotate the live part of the row; the tail takes the insert bus
      CELL_ROT: begin
        q <= is_tail ? ctl.ins : nxt;
      end
      CELL_SHIFT: begin
        q <= nxt;
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

`default_nettype wire
